### design/dts_pkg.sv
// ============================================================================
// dts_pkg: shared types and constants of the disk transfer sequencer
// Holds the disk geometry, the partition table, the event and status codes,
// and the word types that pass between the pipeline stages.
// ============================================================================
package dts_pkg;

    // Disk geometry and transfer sizes. All sizes are powers of two, so the
    // block-to-position split and the sector count are plain bit selects.
    localparam int SECTORS_PER_TRACK   = 16;
    localparam int TRACKS_PER_CYLINDER = 4;
    localparam int RETRY_LIMIT         = 10;
    localparam int SECTOR_BYTES        = 512;

    localparam int SECTOR_SHIFT = $clog2(SECTORS_PER_TRACK);
    localparam int TRACK_SHIFT  = $clog2(TRACKS_PER_CYLINDER);
    localparam int BYTE_SHIFT   = $clog2(SECTOR_BYTES);

    localparam int BLOCK_W    = 16;
    localparam int COUNT_W    = 16;
    localparam int ADDR_W     = 22;
    localparam int PART_W     = 3;
    localparam int CYL_W      = 10;
    localparam int TRACK_W    = 2;
    localparam int SECT_W     = 4;
    localparam int STATUS_W   = 3;
    localparam int ERR_W      = 4;
    localparam int SPAN_W     = BLOCK_W + 1;
    localparam int NSEC_W     = COUNT_W + 1 - BYTE_SHIFT;

    // Input word kinds.
    localparam logic KIND_REQUEST    = 1'b0;
    localparam logic KIND_COMPLETION = 1'b1;

    // Result word kinds.
    localparam logic RESULT_COMMAND = 1'b0;
    localparam logic RESULT_FINISH  = 1'b1;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_RANGE   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_IO_ERROR    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BUSY        = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_PRESENT = 3'd4;

    typedef struct packed {
        logic                kind;
        logic [PART_W-1:0]   partition;
        logic [BLOCK_W-1:0]  block_number;
        logic [COUNT_W-1:0]  byte_count;
        logic                read_request;
        logic [ADDR_W-1:0]   buffer_address;
        logic                sector_error;
    } dts_item_t;

    typedef struct packed {
        logic                result_kind;
        logic [CYL_W-1:0]    cylinder;
        logic [TRACK_W-1:0]  track;
        logic [SECT_W-1:0]   sector;
        logic                read_command;
        logic [ADDR_W-1:0]   sector_address;
        logic                retry_flag;
        logic [COUNT_W-1:0]  residual_bytes;
        logic [STATUS_W-1:0] status;
    } dts_result_t;

    // Highest block count (exclusive) allowed within each partition. The two
    // partitions that run to the end of the disk stop at the 16-bit limit.
    function automatic logic [SPAN_W-1:0] part_limit(input logic [PART_W-1:0] p);
        logic [SPAN_W-1:0] lim;
        unique case (p)
            3'd0:    lim = 17'd7168;
            3'd1:    lim = 17'd12480;
            3'd2:    lim = 17'd34688;
            3'd3:    lim = 17'd58368;
            3'd4:    lim = 17'd9856;
            3'd5:    lim = 17'd19648;
            3'd6:    lim = 17'd41856;
            default: lim = 17'd65536;
        endcase
        return lim;
    endfunction

    // First absolute block of each partition.
    function automatic logic [BLOCK_W-1:0] part_offset(input logic [PART_W-1:0] p);
        logic [BLOCK_W-1:0] off;
        unique case (p)
            3'd1, 3'd2, 3'd3: off = 16'd7168;
            default:          off = 16'd0;
        endcase
        return off;
    endfunction

endpackage

### design/dts_input_stage.sv
// ============================================================================
// dts_input_stage: input word register
// Captures one input word and holds it until the sequencer takes it.
// ============================================================================
module dts_input_stage
    import dts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  dts_item_t in_item,
    input  logic      advance,
    output logic      item_valid,
    output dts_item_t item
);

    logic      valid_reg;
    logic      valid_next;
    logic      load;
    dts_item_t item_reg;

    // The register can take a new word when it is empty or is handing its
    // word on in this same cycle.
    assign in_stall = valid_reg && !advance;
    assign load     = in_valid && !in_stall;

    always_comb
    begin
        priority if (load)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            item_reg <= in_item;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

### design/dts_sequencer.sv
// ============================================================================
// dts_sequencer: transfer state and per-word decision logic
// Holds the active transfer and turns each request or completion into at
// most one sector command or finish word.
// ============================================================================
module dts_sequencer
    import dts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        device_present,
    input  logic        fire,
    input  dts_item_t   item,
    output logic        res_valid,
    output dts_result_t res
);

    logic               active_reg,  active_next;
    logic [BLOCK_W-1:0] block_reg,   block_next;
    logic [COUNT_W-1:0] bytes_reg,   bytes_next;
    logic [ADDR_W-1:0]  addr_reg,    addr_next;
    logic               dir_reg,     dir_next;
    logic [ERR_W-1:0]   err_reg,     err_next;

    logic [SPAN_W-1:0]  cnt_round;
    logic [NSEC_W-1:0]  nsec_raw;
    logic [NSEC_W-1:0]  nsec;
    logic [SPAN_W-1:0]  span;
    logic               range_ok;
    logic [ERR_W:0]     err_inc;

    logic               emit_cmd;
    logic               emit_retry;
    logic               emit_fin;
    logic [STATUS_W-1:0] fin_status;
    logic [COUNT_W-1:0] fin_residual;

    // Sector count of the request, rounded up, and never below one.
    assign cnt_round = {1'b0, item.byte_count} + SPAN_W'(SECTOR_BYTES - 1);
    assign nsec_raw  = cnt_round[SPAN_W-1:BYTE_SHIFT];
    assign nsec      = (nsec_raw == '0) ? NSEC_W'(1) : nsec_raw;
    assign span      = {1'b0, item.block_number} + SPAN_W'(nsec);
    assign range_ok  = span <= part_limit(item.partition);
    assign err_inc   = {1'b0, err_reg} + 5'd1;

    always_comb
    begin
        active_next  = active_reg;
        block_next   = block_reg;
        bytes_next   = bytes_reg;
        addr_next    = addr_reg;
        dir_next     = dir_reg;
        err_next     = err_reg;
        emit_cmd     = 1'b0;
        emit_retry   = 1'b0;
        emit_fin     = 1'b0;
        fin_status   = ST_OK;
        fin_residual = '0;

        if (fire)
        begin
            if (item.kind == KIND_REQUEST)
            begin
                priority if (!device_present)
                begin
                    emit_fin   = 1'b1;
                    fin_status = ST_NOT_PRESENT;
                end
                else if (active_reg)
                begin
                    emit_fin   = 1'b1;
                    fin_status = ST_BUSY;
                end
                else if (!range_ok)
                begin
                    emit_fin   = 1'b1;
                    fin_status = ST_BAD_RANGE;
                end
                else
                begin
                    active_next = 1'b1;
                    block_next  = item.block_number + part_offset(item.partition);
                    bytes_next  = item.byte_count;
                    addr_next   = item.buffer_address;
                    dir_next    = item.read_request;
                    err_next    = '0;
                    emit_cmd    = 1'b1;
                end
            end
            else if (active_reg && device_present)
            begin
                priority if (item.sector_error)
                begin
                    if (err_inc <= (ERR_W + 1)'(RETRY_LIMIT))
                    begin
                        err_next   = err_inc[ERR_W-1:0];
                        emit_cmd   = 1'b1;
                        emit_retry = 1'b1;
                    end
                    else
                    begin
                        active_next  = 1'b0;
                        err_next     = '0;
                        emit_fin     = 1'b1;
                        fin_status   = ST_IO_ERROR;
                        fin_residual = bytes_reg;
                    end
                end
                else if (bytes_reg > COUNT_W'(SECTOR_BYTES))
                begin
                    bytes_next = bytes_reg - COUNT_W'(SECTOR_BYTES);
                    addr_next  = addr_reg + ADDR_W'(SECTOR_BYTES);
                    block_next = block_reg + BLOCK_W'(1);
                    emit_cmd   = 1'b1;
                end
                else
                begin
                    bytes_next  = '0;
                    active_next = 1'b0;
                    err_next    = '0;
                    emit_fin    = 1'b1;
                end
            end
        end
    end

    // A command always describes the transfer state as it stands afterwards.
    always_comb
    begin
        res = '0;
        if (emit_fin)
        begin
            res.result_kind    = RESULT_FINISH;
            res.residual_bytes = fin_residual;
            res.status         = fin_status;
        end
        else
        begin
            res.result_kind    = RESULT_COMMAND;
            res.cylinder       = CYL_W'(block_next >> (SECTOR_SHIFT + TRACK_SHIFT));
            res.track          = TRACK_W'(block_next >> SECTOR_SHIFT);
            res.sector         = SECT_W'(block_next);
            res.read_command   = dir_next;
            res.sector_address = addr_next;
            res.retry_flag     = emit_retry;
            res.residual_bytes = bytes_next;
            res.status         = ST_OK;
        end
    end

    assign res_valid = emit_cmd || emit_fin;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            block_reg  <= '0;
            bytes_reg  <= '0;
            addr_reg   <= '0;
            dir_reg    <= 1'b0;
            err_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            block_reg  <= block_next;
            bytes_reg  <= bytes_next;
            addr_reg   <= addr_next;
            dir_reg    <= dir_next;
            err_reg    <= err_next;
        end
    end

    // The retry counter never runs past its limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        err_reg <= ERR_W'(RETRY_LIMIT))
        else $error("retry counter beyond limit");

    // Without an active transfer there is no pending error count.
    assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> err_reg == '0)
        else $error("error count kept while idle");

    // A successful or failed finish ends the transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        emit_fin && (fin_status == ST_OK || fin_status == ST_IO_ERROR)
        |=> !active_reg)
        else $error("transfer still active after finish");

    // A completion with no controller attached leaves the transfer alone.
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.kind == KIND_COMPLETION && !device_present
        |=> $stable(active_reg) && $stable(block_reg) && $stable(err_reg))
        else $error("stray completion changed the transfer");

endmodule

### design/dts_output_stage.sv
// ============================================================================
// dts_output_stage: result word register
// Holds one result word until the receiver takes it.
// ============================================================================
module dts_output_stage
    import dts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  dts_result_t res,
    output logic        free,
    output logic        out_valid,
    input  logic        out_stall,
    output dts_result_t out_res
);

    logic        valid_reg;
    logic        valid_next;
    dts_result_t res_reg;

    // Empty, or emptied at this edge by the receiver.
    assign free = !valid_reg || !out_stall;

    always_comb
    begin
        priority if (load)
            valid_next = 1'b1;
        else if (free)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

### design/disk_transfer_sequencer.sv
// ============================================================================
// disk_transfer_sequencer: multi-sector disk transfer sequencer
// Validates transfer requests against the partition table and issues one
// cylinder/track/sector command per sector, with retry on sector errors.
// ============================================================================
// Usage:
// Input words arrive on in_valid/in_stall. A word with kind 0 is a transfer
// request (partition, block_number, byte_count, read_request,
// buffer_address); a word with kind 1 reports completion of the last
// commanded sector, with sector_error set on failure.
// Each input word gives at most one result word on out_valid/out_stall:
// either a sector command (result_kind 0) or a finish word (result_kind 1)
// carrying the status and residual byte count. A completion arriving with no
// transfer active, or with no controller attached, gives no result.
// An accepted word is held first in the input register; its result is then
// held in the result register, from which it drives the outputs.
// Throughput is one word per cycle; the decision logic between the two
// registers is one pass of adds, compares and a table lookup, and the
// transfer state it updates is ready for the next word in the next cycle.
// The single configuration register, device_present, is written through
// config_write/config_data and should only change while the block is idle.
// Reset clears the transfer state, the register and both pipeline stages.
// When the receiver stalls, the result word holds; the input register then
// fills and in_stall rises, so at most two words are held inside the block.
// ============================================================================
module disk_transfer_sequencer
    import dts_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 config_write,
    input  logic                 config_data,

    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 kind,
    input  logic [PART_W-1:0]    partition,
    input  logic [BLOCK_W-1:0]   block_number,
    input  logic [COUNT_W-1:0]   byte_count,
    input  logic                 read_request,
    input  logic [ADDR_W-1:0]    buffer_address,
    input  logic                 sector_error,

    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 result_kind,
    output logic [CYL_W-1:0]     cylinder,
    output logic [TRACK_W-1:0]   track,
    output logic [SECT_W-1:0]    sector,
    output logic                 read_command,
    output logic [ADDR_W-1:0]    sector_address,
    output logic                 retry_flag,
    output logic [COUNT_W-1:0]   residual_bytes,
    output logic [STATUS_W-1:0]  status
);

    logic        present_reg;
    logic        present_next;

    dts_item_t   in_item;
    dts_item_t   item;
    logic        item_valid;
    logic        out_free;
    logic        fire;
    logic        res_valid;
    dts_result_t res;
    dts_result_t out_res;

    // Configuration register.
    assign present_next = config_write ? config_data : present_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            present_reg <= 1'b0;
        else
            present_reg <= present_next;
    end

    assign in_item.kind           = kind;
    assign in_item.partition      = partition;
    assign in_item.block_number   = block_number;
    assign in_item.byte_count     = byte_count;
    assign in_item.read_request   = read_request;
    assign in_item.buffer_address = buffer_address;
    assign in_item.sector_error   = sector_error;

    // A held word is processed whenever the result register can take its
    // result. Words that give no result also wait for that, which keeps the
    // handshake simple and costs nothing in the sustained rate.
    assign fire = item_valid && out_free;

    dts_input_stage u_input (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .advance    (out_free),
        .item_valid (item_valid),
        .item       (item)
    );

    dts_sequencer u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .device_present (present_reg),
        .fire           (fire),
        .item           (item),
        .res_valid      (res_valid),
        .res            (res)
    );

    dts_output_stage u_output (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_valid),
        .res       (res),
        .free      (out_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign result_kind    = out_res.result_kind;
    assign cylinder       = out_res.cylinder;
    assign track          = out_res.track;
    assign sector         = out_res.sector;
    assign read_command   = out_res.read_command;
    assign sector_address = out_res.sector_address;
    assign retry_flag     = out_res.retry_flag;
    assign residual_bytes = out_res.residual_bytes;
    assign status         = out_res.status;

endmodule
